// File: sv/htfs_pkg.sv
package htfs_pkg;

  // Field widths fixed by the port list
  localparam int CMD_W     = 2;
  localparam int REF_W     = 32;
  localparam int SLOT_W    = 10;
  localparam int STAT_W    = 2;
  localparam int MAX_REF_W = 64;

  // Defaults for the top-level parameters
  localparam int DEF_SLOTS    = 1024;
  localparam int DEF_REF_BITS = 32;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_NULL  = 2'd3;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the input beat and issue memory reads
    logic execute;  // resolve the command, write memories, load the result
  } ctrl_cmd_t;

endpackage

// File: sv/htfs_ctrl.sv
module htfs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output htfs_pkg::ctrl_cmd_t cmd
);

  htfs_pkg::state_t state;
  htfs_pkg::state_t state_next;
  logic             out_valid_next;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= htfs_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Take a beat in idle, execute once the result register is free
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    cmd            = '0;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    unique case (state)
      htfs_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = htfs_pkg::S_EXEC;
        end
      end
      htfs_pkg::S_EXEC: begin
        if (!out_valid || !out_stall) begin
          cmd.execute    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = htfs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = htfs_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall = (state == htfs_pkg::S_EXEC);

endmodule

// File: sv/htfs_datapath.sv
module htfs_datapath #(
  parameter int SLOTS    = htfs_pkg::DEF_SLOTS,
  parameter int REF_BITS = htfs_pkg::DEF_REF_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  htfs_pkg::ctrl_cmd_t           cmd,
  input  logic [htfs_pkg::CMD_W-1:0]    command,
  input  logic [htfs_pkg::REF_W-1:0]    object_ref,
  input  logic [htfs_pkg::SLOT_W-1:0]   slot_id,
  output logic [htfs_pkg::SLOT_W-1:0]   result_slot,
  output logic [htfs_pkg::REF_W-1:0]    result_ref,
  output logic [htfs_pkg::STAT_W-1:0]   status
);

  localparam int IDXW = $clog2(SLOTS);
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int CMPW = (CW > htfs_pkg::SLOT_W) ? CW : htfs_pkg::SLOT_W;

  // Memories
  logic [REF_BITS-1:0] slot_table [SLOTS];
  logic [IDXW-1:0]     free_stack [SLOTS];

  // Counters
  logic [CW-1:0] free_count;
  logic [CW-1:0] free_count_next;
  logic [CW-1:0] high_water;
  logic [CW-1:0] high_water_next;

  // Captured beat and registered read data
  logic [htfs_pkg::CMD_W-1:0]  cmd_q;
  logic [REF_BITS-1:0]         obj_q;
  logic [htfs_pkg::SLOT_W-1:0] id_q;
  logic [REF_BITS-1:0]         table_rd;
  logic [IDXW-1:0]             stack_rd;

  logic [htfs_pkg::MAX_REF_W-1:0] obj_ext;
  logic [CMPW-1:0]                in_id_ext;
  logic [CW-1:0]                  fc_m1;
  logic [CMPW-1:0]                id_ext;
  logic [CMPW-1:0]                hw_ext;
  logic [CMPW-1:0]                grant_ext;
  logic [htfs_pkg::MAX_REF_W-1:0] rd_ext;
  logic [IDXW-1:0]                grant;
  logic [IDXW-1:0]                id_idx;
  logic                           occupied;
  logic                           use_stack;
  logic                           has_room;

  logic                        tbl_we;
  logic [IDXW-1:0]             tbl_waddr;
  logic [REF_BITS-1:0]         tbl_wdata;
  logic                        stk_we;
  logic [htfs_pkg::SLOT_W-1:0] res_slot_next;
  logic [htfs_pkg::REF_W-1:0]  res_ref_next;
  logic [htfs_pkg::STAT_W-1:0] status_next;

  assign obj_ext   = htfs_pkg::MAX_REF_W'(object_ref);
  assign in_id_ext = CMPW'(slot_id);
  assign fc_m1     = free_count - CW'(1);

  // Latch the beat and issue both memory reads
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q    <= command;
      obj_q    <= obj_ext[REF_BITS-1:0];
      id_q     <= slot_id;
      table_rd <= slot_table[in_id_ext[IDXW-1:0]];
      stack_rd <= free_stack[fc_m1[IDXW-1:0]];
    end
    if (tbl_we) begin
      slot_table[tbl_waddr] <= tbl_wdata;
    end
    if (stk_we) begin
      free_stack[free_count[IDXW-1:0]] <= id_idx;
    end
  end

  // Resolve the captured command against the read data
  always_comb begin
    id_ext    = CMPW'(id_q);
    hw_ext    = CMPW'(high_water);
    id_idx    = id_ext[IDXW-1:0];
    occupied  = (id_ext < hw_ext) && (table_rd != '0);
    use_stack = (free_count != '0);
    has_room  = (high_water != CW'(SLOTS));
    grant     = use_stack ? stack_rd : high_water[IDXW-1:0];
    grant_ext = CMPW'(grant);
    rd_ext    = htfs_pkg::MAX_REF_W'(table_rd);

    tbl_we          = 1'b0;
    tbl_waddr       = grant;
    tbl_wdata       = obj_q;
    stk_we          = 1'b0;
    free_count_next = free_count;
    high_water_next = high_water;
    res_slot_next   = id_q;
    res_ref_next    = '0;
    status_next     = htfs_pkg::ST_OK;

    unique case (cmd_q)
      htfs_pkg::CMD_ALLOC: begin
        res_slot_next = '0;
        priority if (obj_q == '0) begin
          status_next = htfs_pkg::ST_NULL;
        end else if (use_stack || has_room) begin
          tbl_we        = cmd.execute;
          res_slot_next = grant_ext[htfs_pkg::SLOT_W-1:0];
          if (use_stack) begin
            free_count_next = fc_m1;
          end else begin
            high_water_next = high_water + CW'(1);
          end
        end else begin
          status_next = htfs_pkg::ST_FULL;
        end
      end
      htfs_pkg::CMD_LOOKUP: begin
        if (occupied) begin
          res_ref_next = rd_ext[htfs_pkg::REF_W-1:0];
        end else begin
          status_next = htfs_pkg::ST_EMPTY;
        end
      end
      htfs_pkg::CMD_RELEASE: begin
        if (occupied && (free_count != CW'(SLOTS))) begin
          tbl_we          = cmd.execute;
          tbl_waddr       = id_idx;
          tbl_wdata       = '0;
          stk_we          = cmd.execute;
          free_count_next = free_count + CW'(1);
        end else begin
          status_next = htfs_pkg::ST_EMPTY;
        end
      end
      default: begin
        // unknown command: echo the slot, change nothing
      end
    endcase
  end

  // Advance the counters on execute
  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= '0;
      high_water <= '0;
    end else if (cmd.execute) begin
      free_count <= free_count_next;
      high_water <= high_water_next;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      result_slot <= res_slot_next;
      result_ref  <= res_ref_next;
      status      <= status_next;
    end
  end

endmodule

// File: sv/handle_table_free_stack.sv
// An accepted input beat is latched into the capture registers, then resolved in the execute
// state into the result register. The input stalls in execute, so the next beat waits for the
// write: the table and free-stack memories are read in capture and written in execute.
// A stalled result holds the block in execute until the result register frees up.
// Reset (synchronous, active high) clears the free count, the high-water mark and the FSM;
// memory contents are not cleared, since only written entries are ever read.
module handle_table_free_stack #(
  parameter int SLOTS    = htfs_pkg::DEF_SLOTS,
  parameter int REF_BITS = htfs_pkg::DEF_REF_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [htfs_pkg::CMD_W-1:0]  command,
  input  logic [htfs_pkg::REF_W-1:0]  object_ref,
  input  logic [htfs_pkg::SLOT_W-1:0] slot_id,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [htfs_pkg::SLOT_W-1:0] result_slot,
  output logic [htfs_pkg::REF_W-1:0]  result_ref,
  output logic [htfs_pkg::STAT_W-1:0] status
);

  htfs_pkg::ctrl_cmd_t cmd;

  htfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  htfs_datapath #(
    .SLOTS    (SLOTS),
    .REF_BITS (REF_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .command     (command),
    .object_ref  (object_ref),
    .slot_id     (slot_id),
    .result_slot (result_slot),
    .result_ref  (result_ref),
    .status      (status)
  );

  // An accepted beat blocks the input for the execute cycle
  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an accepted beat");

  // A new result appears only out of the execute cycle
  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without an execute cycle");

  // Only a successful lookup returns a reference
  a_ref_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != htfs_pkg::ST_OK)) |-> (result_ref == '0))
    else $error("reference returned with a failing status");

  // Failed allocations report slot zero
  a_fail_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == htfs_pkg::ST_FULL || status == htfs_pkg::ST_NULL))
      |-> (result_slot == '0))
    else $error("nonzero slot on a failed allocate");

endmodule
